// ----- design/mbrtu_pkg.sv -----
package mbrtu_pkg;

    localparam int MAX_FRAME  = 256;
    localparam int CNT_W      = $clog2(MAX_FRAME + 1);
    localparam int HEADER_LEN = 6;
    localparam int LEN_W      = 9;
    localparam int GUARD_W    = 16;
    localparam int MINLEN_W   = 9;
    localparam int ADDR_W     = 3;

    localparam logic [15:0]         CRC_INIT     = 16'hFFFF;
    localparam logic [15:0]         CRC_POLY     = 16'hA001;
    localparam logic [GUARD_W-1:0]  GUARD_RESET  = 16'd10;
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 9'd4;
    localparam logic [MINLEN_W-1:0] MINLEN_FLOOR = 9'd2;
    localparam logic [GUARD_W-1:0]  GAP_MAX      = 16'hFFFF;

    typedef enum logic [0:0] {
        REG_GUARD_TICKS = 1'b0,
        REG_MIN_LENGTH  = 1'b1
    } reg_index_t;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_SHORT    = 2'd1,
        ST_CRC_ERR  = 2'd2,
        ST_OVERFLOW = 2'd3
    } frame_status_t;

    typedef struct packed {
        frame_status_t status;
        logic [LEN_W-1:0] length;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] data_address;
        logic [15:0] item_count;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- design/modbus_rtu_frame_receiver.sv -----
// Modbus RTU frame receiver with CRC-16/MODBUS check.
// The request channel (s_valid, s_ready, s_action, s_data_byte) carries either
// one received byte or one timer tick. Bytes are collected into a frame while a
// running CRC is updated in the same cycle. When guard_ticks silent ticks follow
// the last byte, the frame closes and one result is sent on the m_ channel with
// its status, length and the header fields from the first six bytes.
// A new request may be accepted in every cycle while s_ready is high; the CRC
// byte update over the running CRC register is combinational. A closing tick
// registers its result in the result register, or in the skid register while
// the result register holds a result that the receiver has not yet taken.
// A result register and a skid register sit on the output side, so requests
// keep flowing while one result waits. Only when both hold results does
// s_ready drop, until the receiver takes one.
// The APB port holds guard_ticks at address 0 and min_length at address 4;
// pready is always high. Reset restores the register defaults (10 and 4),
// clears the frame state and empties the output registers.
module modbus_rtu_frame_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_frame_status,
    output logic [mbrtu_pkg::LEN_W-1:0]   m_frame_length,
    output logic [7:0]                    m_slave_address,
    output logic [7:0]                    m_function_code,
    output logic [15:0]                   m_data_address,
    output logic [15:0]                   m_item_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbrtu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mbrtu_pkg::*;

    logic [GUARD_W-1:0]  guard_reg;
    logic [MINLEN_W-1:0] minlen_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [15:0]         crc_reg, crc_next;
    logic [GUARD_W-1:0]  gap_reg, gap_next;
    logic                ovf_reg, ovf_next;
    logic [7:0]          hdr_reg [HEADER_LEN];
    logic [7:0]          hdr_next [HEADER_LEN];

    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    result_t             skid_reg, skid_next;
    logic                skid_valid_reg, skid_valid_next;

    logic                s_accept;
    logic                cfg_write;
    reg_index_t          cfg_index;
    logic                emit;
    result_t             result;
    logic [GUARD_W-1:0]  gap_inc;
    logic [MINLEN_W-1:0] minlen_eff;
    frame_status_t       status;

    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb begin
        case (cfg_index)
            REG_GUARD_TICKS: prdata = {16'h0000, guard_reg};
            REG_MIN_LENGTH:  prdata = {23'h000000, minlen_reg};
            default:         prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg  <= GUARD_RESET;
            minlen_reg <= MINLEN_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_GUARD_TICKS: guard_reg  <= pwdata[GUARD_W-1:0];
                REG_MIN_LENGTH:  minlen_reg <= pwdata[MINLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign gap_inc    = (gap_reg == GAP_MAX) ? gap_reg : gap_reg + 16'd1;
    assign minlen_eff = (minlen_reg < MINLEN_FLOOR) ? MINLEN_FLOOR : minlen_reg;

    always_comb begin
        if (ovf_reg) begin
            status = ST_OVERFLOW;
        end else if (32'(count_reg) < 32'(minlen_eff)) begin
            status = ST_SHORT;
        end else if (crc_reg != 16'h0000) begin
            status = ST_CRC_ERR;
        end else begin
            status = ST_GOOD;
        end
        result.status        = status;
        result.length        = LEN_W'(count_reg);
        result.slave_address = hdr_reg[0];
        result.function_code = hdr_reg[1];
        result.data_address  = {hdr_reg[2], hdr_reg[3]};
        result.item_count    = {hdr_reg[4], hdr_reg[5]};
    end

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        gap_next   = gap_reg;
        ovf_next   = ovf_reg;
        hdr_next   = hdr_reg;
        emit       = 1'b0;
        if (s_accept) begin
            case (action_t'(s_action))
                ACT_BYTE: begin
                    if (32'(count_reg) < MAX_FRAME) begin
                        if (32'(count_reg) < HEADER_LEN) begin
                            hdr_next[count_reg[2:0]] = s_data_byte;
                        end
                        crc_next   = crc16_byte(crc_reg, s_data_byte);
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    gap_next = '0;
                end
                ACT_TICK: begin
                    if (count_reg != '0 || ovf_reg) begin
                        if (gap_inc < guard_reg) begin
                            gap_next = gap_inc;
                        end else begin
                            emit       = 1'b1;
                            count_next = '0;
                            crc_next   = CRC_INIT;
                            gap_next   = '0;
                            ovf_next   = 1'b0;
                            for (int i = 0; i < HEADER_LEN; i++) begin
                                hdr_next[i] = 8'h00;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = result;
                skid_valid_next = emit;
            end else begin
                out_next       = result;
                out_valid_next = emit;
            end
        end else if (emit) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            crc_reg        <= CRC_INIT;
            gap_reg        <= '0;
            ovf_reg        <= 1'b0;
            for (int i = 0; i < HEADER_LEN; i++) begin
                hdr_reg[i] <= 8'h00;
            end
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            gap_reg        <= gap_next;
            ovf_reg        <= ovf_next;
            hdr_reg        <= hdr_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_status  = out_reg.status;
    assign m_frame_length  = out_reg.length;
    assign m_slave_address = out_reg.slave_address;
    assign m_function_code = out_reg.function_code;
    assign m_data_address  = out_reg.data_address;
    assign m_item_count    = out_reg.item_count;

endmodule
